@@ design/bdq_pkg.sv @@
// Shared types and constants for the bounded deque with key search.
// Used by every module of the block but bdq_ram; depends on nothing else.
package bdq_pkg;

	localparam int ID_W        = 32;
	localparam int NAME_W      = 64;
	localparam int KIND_W      = 3;
	localparam int MAX_RESULTS = 16;
	localparam int HIT_W       = $clog2(MAX_RESULTS);
	localparam int IN_TDATA_W  = 96;
	localparam int OUT_TDATA_W = 104;
	localparam int OUT_PAD_W   = OUT_TDATA_W - (1 + ID_W + NAME_W + 2);

	// Kind codes as they arrive on the input channel.
	localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 3'd0;
	localparam logic [KIND_W-1:0] KIND_PUSH_BACK  = 3'd1;
	localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 3'd2;
	localparam logic [KIND_W-1:0] KIND_POP_BACK   = 3'd3;
	localparam logic [KIND_W-1:0] KIND_FIND_ID    = 3'd4;
	localparam logic [KIND_W-1:0] KIND_FIND_NAME  = 3'd5;

	// Operation after classification; unused kinds become OP_BAD.
	typedef enum logic [2:0] {
		OP_PUSH_FRONT = 3'd0,
		OP_PUSH_BACK  = 3'd1,
		OP_POP_FRONT  = 3'd2,
		OP_POP_BACK   = 3'd3,
		OP_FIND_ID    = 3'd4,
		OP_FIND_NAME  = 3'd5,
		OP_BAD        = 3'd6
	} op_t;

	typedef struct packed {
		op_t                     op;
		logic signed [ID_W-1:0]  id;
		logic [NAME_W-1:0]       name;
	} cmd_t;

	typedef struct packed {
		logic                    status;
		logic signed [ID_W-1:0]  found_id;
		logic [NAME_W-1:0]       found_name;
		logic                    now_empty;
		logic                    now_full;
		logic                    last;
	} res_t;

endpackage

@@ design/bounded_deque_with_key_search_core.sv @@
// Top level of the bounded deque with key search.
// Depends on bdq_pkg, bdq_front, bdq_cmd_fifo, bdq_back and bdq_ram.
//
// Usage: each item on the s_axis channel is one command. Its kind travels in
// s_axis_tuser (push front, push back, pop front, pop back, find by id, find
// by name); s_axis_tdata carries the record id and the 8-byte name. Results
// leave on m_axis; m_axis_tlast marks the final result of an item. Every
// command gives exactly one result except a name search with matches, which
// gives one result per match, front to back.
// A front stage registers the item, trims the name at its first zero byte
// and decodes the kind; a two-entry queue hands commands to the engine,
// which owns the ring pointers and the record RAM.
// A push or pop goes through the front stage, queue and result register to
// m_axis_tvalid; such items sustain one per cycle while m_axis_tready is high.
// A search scans the live records one per cycle through the RAM read port,
// pausing while a match waits on a full result register, and holds the engine
// until all live records are read or an id hit or sixteenth name match ends it.
// Reset empties the deque (front pointer and count cleared); record contents
// are not cleared, and no clearing pass is needed. When the receiver holds
// m_axis_tready low, the result register holds its item, the engine stalls,
// and the queue and front stage keep taking items until they fill.
module bounded_deque_with_key_search_core import bdq_pkg::*; #(
	parameter int CAPACITY   = 16,
	parameter int NAME_BYTES = 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // key_id[31:0], key_name[95:32]
	input  logic [KIND_W-1:0]      s_axis_tuser,   // kind[2:0]
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // status[0], found_id[32:1],
	                                               // found_name[96:33], now_empty[97],
	                                               // now_full[98], zero[103:99]
	output logic                   m_axis_tlast
);

	logic fe_valid;
	logic fe_ready;
	cmd_t fe_cmd;
	logic q_valid;
	logic q_ready;
	cmd_t q_cmd;
	res_t res;

	bdq_front #(
		.NAME_BYTES (NAME_BYTES)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_kind   (s_axis_tuser),
		.in_id     (s_axis_tdata[ID_W-1:0]),
		.in_name   (s_axis_tdata[ID_W +: NAME_W]),
		.cmd_valid (fe_valid),
		.cmd_ready (fe_ready),
		.cmd       (fe_cmd)
	);

	bdq_cmd_fifo u_cmd_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fe_valid),
		.push_ready (fe_ready),
		.push_cmd   (fe_cmd),
		.pop_valid  (q_valid),
		.pop_ready  (q_ready),
		.pop_cmd    (q_cmd)
	);

	bdq_back #(
		.CAPACITY (CAPACITY)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (q_valid),
		.cmd_ready (q_ready),
		.cmd       (q_cmd),
		.res_valid (m_axis_tvalid),
		.res_ready (m_axis_tready),
		.res       (res)
	);

	// Pack the result fields from the lowest bit up.
	assign m_axis_tdata = {OUT_PAD_W'(0), res.now_full, res.now_empty,
		res.found_name, res.found_id, res.status};
	assign m_axis_tlast = res.last;

endmodule

@@ design/bdq_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module bdq_ram #(
	parameter int WIDTH = 96,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

@@ design/bdq_front.sv @@
// Front end: accepts input items, normalizes the name and classifies the kind.
// Depends on bdq_pkg.
module bdq_front import bdq_pkg::*; #(
	parameter int NAME_BYTES = 8
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [KIND_W-1:0]       in_kind,
	input  logic signed [ID_W-1:0]  in_id,
	input  logic [NAME_W-1:0]       in_name,
	output logic                    cmd_valid,
	input  logic                    cmd_ready,
	output cmd_t                    cmd
);

	logic cmd_valid_q;
	cmd_t cmd_q;
	op_t  op_dec;

	// A name ends at its first zero byte or at NAME_BYTES bytes.
	function automatic logic [NAME_W-1:0] clean_name(input logic [NAME_W-1:0] raw);
		logic              keep;
		logic [NAME_W-1:0] res;
		keep = 1'b1;
		res  = '0;
		for (int b = 0; b < NAME_W / 8; b++) begin
			keep = keep && (b < NAME_BYTES) && (raw[8*b +: 8] != 8'd0);
			if (keep) begin
				res[8*b +: 8] = raw[8*b +: 8];
			end
		end
		return res;
	endfunction

	always_comb begin
		unique case (in_kind)
			KIND_PUSH_FRONT: op_dec = OP_PUSH_FRONT;
			KIND_PUSH_BACK:  op_dec = OP_PUSH_BACK;
			KIND_POP_FRONT:  op_dec = OP_POP_FRONT;
			KIND_POP_BACK:   op_dec = OP_POP_BACK;
			KIND_FIND_ID:    op_dec = OP_FIND_ID;
			KIND_FIND_NAME:  op_dec = OP_FIND_NAME;
			default:         op_dec = OP_BAD;
		endcase
	end

	assign in_ready  = !cmd_valid_q || cmd_ready;
	assign cmd_valid = cmd_valid_q;
	assign cmd       = cmd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_valid_q <= 1'b0;
		end else if (in_ready) begin
			cmd_valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			cmd_q.op   <= op_dec;
			cmd_q.id   <= in_id;
			cmd_q.name <= clean_name(in_name);
		end
	end

endmodule

@@ design/bdq_cmd_fifo.sv @@
// Two-entry command queue between the front end and the execution engine.
// Depends on bdq_pkg.
module bdq_cmd_fifo import bdq_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	output logic push_ready,
	input  cmd_t push_cmd,
	output logic pop_valid,
	input  logic pop_ready,
	output cmd_t pop_cmd
);

	localparam int DEPTH = 2;
	localparam int PW    = $clog2(DEPTH);

	cmd_t            entry_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [PW:0]     fill_q;
	logic            do_push;
	logic            do_pop;

	assign push_ready = (fill_q != (PW+1)'(DEPTH));
	assign pop_valid  = (fill_q != '0);
	assign pop_cmd    = entry_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

@@ design/bdq_back.sv @@
// Execution engine: ring state, record RAM, search scan and result register.
// Depends on bdq_pkg and bdq_ram.
module bdq_back import bdq_pkg::*; #(
	parameter int CAPACITY = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	output logic cmd_ready,
	input  cmd_t cmd,
	output logic res_valid,
	input  logic res_ready,
	output res_t res
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int DW = ID_W + NAME_W;
	localparam logic [AW:0]   CAP_S = (AW+1)'(CAPACITY);
	localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_FIN  = 3'b100
	} bstate_t;

	bstate_t                state_q, state_d;
	logic [AW-1:0]          front_q, front_d;
	logic [CW-1:0]          count_q, count_d;
	logic [CW-1:0]          idx_q, idx_d;
	logic                   rdv_q, rdv_d;
	cmd_t                   cur_q, cur_d;
	logic                   pend_v_q, pend_v_d;
	logic signed [ID_W-1:0] pend_id_q, pend_id_d;
	logic [HIT_W-1:0]       hits_q, hits_d;
	logic                   out_v_q;
	res_t                   out_q;

	logic                   out_free;
	logic                   emit;
	res_t                   emit_res;
	logic                   wr_en;
	logic [AW-1:0]          wr_addr;
	logic                   rd_en;
	logic [AW-1:0]          rd_addr;
	logic [DW-1:0]          rd_data;
	logic signed [ID_W-1:0] rd_id;
	logic [NAME_W-1:0]      rd_name;
	logic                   ring_empty;
	logic                   is_full;
	logic [AW-1:0]          front_dec;
	logic [AW-1:0]          front_inc;
	logic                   hit_id;
	logic                   hit_name;
	logic                   stall;
	logic                   done_max;

	// Ring index of a sum that stays below twice the capacity.
	function automatic logic [AW-1:0] wrap(input logic [AW:0] s);
		return (s >= CAP_S) ? AW'(s - CAP_S) : AW'(s);
	endfunction

	bdq_ram #(
		.WIDTH (DW),
		.DEPTH (CAPACITY)
	) u_rec_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data ({cmd.name, cmd.id}),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign rd_id      = rd_data[ID_W-1:0];
	assign rd_name    = rd_data[DW-1:ID_W];
	assign out_free   = !out_v_q || res_ready;
	assign ring_empty = (count_q == '0);
	assign is_full    = (count_q == CAP_C);
	assign front_dec  = (front_q == '0) ? AW'(CAPACITY - 1) : front_q - 1'b1;
	assign front_inc  = wrap({1'b0, front_q} + (AW+1)'(1));
	assign rd_addr    = wrap({1'b0, front_q} + {1'b0, idx_q[AW-1:0]});
	assign hit_id     = rdv_q && (cur_q.op == OP_FIND_ID) && (rd_id == cur_q.id);
	assign hit_name   = rdv_q && (cur_q.op == OP_FIND_NAME) && (rd_name == cur_q.name);
	assign stall      = (hit_id || (hit_name && pend_v_q)) && !out_free;
	assign done_max   = hit_name && (hits_q == HIT_W'(MAX_RESULTS - 1));

	always_comb begin
		state_d   = state_q;
		front_d   = front_q;
		count_d   = count_q;
		idx_d     = idx_q;
		rdv_d     = rdv_q;
		cur_d     = cur_q;
		pend_v_d  = pend_v_q;
		pend_id_d = pend_id_q;
		hits_d    = hits_q;
		cmd_ready = 1'b0;
		emit      = 1'b0;
		emit_res  = '0;
		emit_res.last = 1'b1;
		wr_en     = 1'b0;
		wr_addr   = wrap({1'b0, front_q} + {1'b0, count_q[AW-1:0]});
		rd_en     = 1'b0;

		unique case (state_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					unique case (cmd.op)
						OP_PUSH_FRONT, OP_PUSH_BACK: begin
							if (out_free) begin
								cmd_ready       = 1'b1;
								emit            = 1'b1;
								emit_res.status = is_full;
								if (!is_full) begin
									wr_en   = 1'b1;
									count_d = count_q + 1'b1;
									if (cmd.op == OP_PUSH_FRONT) begin
										front_d = front_dec;
										wr_addr = front_dec;
									end
								end
							end
						end
						OP_POP_FRONT, OP_POP_BACK: begin
							if (out_free) begin
								cmd_ready       = 1'b1;
								emit            = 1'b1;
								emit_res.status = ring_empty;
								if (!ring_empty) begin
									count_d = count_q - 1'b1;
									if (cmd.op == OP_POP_FRONT) begin
										front_d = front_inc;
									end
								end
							end
						end
						OP_FIND_ID, OP_FIND_NAME: begin
							cmd_ready = 1'b1;
							cur_d     = cmd;
							idx_d     = '0;
							rdv_d     = 1'b0;
							pend_v_d  = 1'b0;
							hits_d    = '0;
							state_d   = ST_SCAN;
						end
						default: begin
							if (out_free) begin
								cmd_ready       = 1'b1;
								emit            = 1'b1;
								emit_res.status = 1'b1;
							end
						end
					endcase
				end
			end
			ST_SCAN: begin
				if (!stall) begin
					if (hit_id) begin
						emit                = 1'b1;
						emit_res.found_name = rd_name;
						rdv_d               = 1'b0;
						state_d             = ST_IDLE;
					end else begin
						if (hit_name) begin
							// The held match is not the final one: release it now.
							if (pend_v_q) begin
								emit              = 1'b1;
								emit_res.found_id = pend_id_q;
								emit_res.last     = 1'b0;
							end
							pend_v_d  = 1'b1;
							pend_id_d = rd_id;
							hits_d    = hits_q + 1'b1;
						end
						if (done_max || (idx_q == count_q)) begin
							rdv_d   = 1'b0;
							state_d = ST_FIN;
						end else begin
							rd_en = 1'b1;
							idx_d = idx_q + 1'b1;
							rdv_d = 1'b1;
						end
					end
				end
			end
			ST_FIN: begin
				if (out_free) begin
					emit    = 1'b1;
					state_d = ST_IDLE;
					if ((cur_q.op == OP_FIND_NAME) && pend_v_q) begin
						emit_res.found_id = pend_id_q;
					end else begin
						emit_res.status = 1'b1;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase

		emit_res.now_empty = (count_d == '0);
		emit_res.now_full  = (count_d == CAP_C);
	end

	assign res_valid = out_v_q;
	assign res       = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			front_q  <= '0;
			count_q  <= '0;
			idx_q    <= '0;
			rdv_q    <= 1'b0;
			pend_v_q <= 1'b0;
			hits_q   <= '0;
			out_v_q  <= 1'b0;
		end else begin
			state_q  <= state_d;
			front_q  <= front_d;
			count_q  <= count_d;
			idx_q    <= idx_d;
			rdv_q    <= rdv_d;
			pend_v_q <= pend_v_d;
			hits_q   <= hits_d;
			if (emit) begin
				out_v_q <= 1'b1;
			end else if (res_ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		cur_q     <= cur_d;
		pend_id_q <= pend_id_d;
		if (emit) begin
			out_q <= emit_res;
		end
	end

endmodule
